@@ rtl/mts_pkg.sv @@
package mts_pkg;

    // Token kinds as seen on the result channel
    typedef enum logic [1:0] {
        KIND_LIT  = 2'd0,
        KIND_WORD = 2'd1,
        KIND_STR  = 2'd2
    } kind_t;

    // Tokenizer position
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_STR  = 2'd2
    } mode_t;

    // Character codes
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // One result item
    typedef struct packed {
        logic [7:0] token_byte;
        kind_t      kind;
        logic       last;
        logic       has;
    } result_t;

    // Tokenizer state carried between items
    typedef struct packed {
        mode_t      mode;
        logic       text;
        logic       held_valid;
        logic [7:0] held_char;
        logic       quote_single;
    } state_t;

    function automatic result_t make_res(logic [7:0] b, kind_t k, logic last, logic has);
        result_t r;
        r.token_byte = b;
        r.kind       = k;
        r.last       = last;
        r.has        = has;
        return r;
    endfunction

endpackage

@@ rtl/markup_token_splitter.sv @@
// Markup token splitter.
// Input channel (in_valid / in_stall): one stream byte per item in in_byte, or
// an end-of-stream mark with end_of_input set. Output channel (out_valid /
// out_stall): one token byte per item with its kind, end-of-token mark and
// has_byte flag (clear only for the bare end mark of a truncated string).
// Each input item yields zero, one or two results. The last byte of a word is
// held inside until the next item shows where the word ends.
// A result produced by an item enters the queue when the item is accepted and
// reaches the output behind earlier results. One input item and one result
// per cycle while nothing stalls; results land in a four-entry queue, and
// in_stall rises while more than two entries are occupied, so items that
// yield two results slow the input to the rate at which the receiver drains it.
// Reset clears the tokenizer state and empties the queue. When the receiver
// stalls, the head result holds on the output and the queue absorbs up to
// two more items' worth of results before in_stall is raised.
module markup_token_splitter
    import mts_pkg::*;
#(
    parameter int QDepth = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] token_byte,
    output logic [1:0] token_kind,
    output logic       token_last,
    output logic       has_byte
);

    localparam int CntW = $clog2(QDepth + 1);

    state_t            st_reg;
    state_t            st_next;
    logic [1:0]        res_n;
    result_t           res0;
    result_t           res1;
    result_t           q_reg  [QDepth];
    result_t           q_next [QDepth];
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic [CntW-1:0]   base;
    logic [CntW-1:0]   push_n;
    logic              accept;
    logic              pop;

    mts_step u_step (
        .st           (st_reg),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .st_next      (st_next),
        .res_n        (res_n),
        .res0         (res0),
        .res1         (res1)
    );

    // Handshake
    assign in_stall  = (count_reg > CntW'(QDepth - 2));
    assign accept    = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign push_n    = accept ? CntW'(res_n) : '0;
    assign base      = count_reg - CntW'(pop);

    // Shift out the head and write new results behind the remaining entries
    always_comb
    begin
        for (int i = 0; i < QDepth; i++)
        begin
            if (pop && (i < QDepth - 1))
            begin
                q_next[i] = q_reg[i + 1];
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
            if ((push_n != '0) && (CntW'(i) == base))
            begin
                q_next[i] = res0;
            end
            else if ((push_n == CntW'(2)) && (CntW'(i) == base + CntW'(1)))
            begin
                q_next[i] = res1;
            end
        end
        count_next = base + push_n;
    end

    // Hold tokenizer state and queue fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode         <= MODE_IDLE;
            st_reg.text         <= 1'b0;
            st_reg.held_valid   <= 1'b0;
            st_reg.held_char    <= 8'h00;
            st_reg.quote_single <= 1'b0;
            count_reg           <= '0;
        end
        else
        begin
            if (accept)
            begin
                st_reg <= st_next;
            end
            count_reg <= count_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDepth; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    // Present the head result
    assign token_byte = q_reg[0].token_byte;
    assign token_kind = q_reg[0].kind;
    assign token_last = q_reg[0].last;
    assign has_byte   = q_reg[0].has;

endmodule

@@ rtl/mts_step.sv @@
module mts_step
    import mts_pkg::*;
(
    input  state_t     st,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output state_t     st_next,
    output logic [1:0] res_n,
    output result_t    res0,
    output result_t    res1
);

    logic       in_word;
    logic       is_lit;
    logic       is_blank;
    logic       is_break;
    logic       is_quote;
    logic [7:0] delim;

    // Classify the incoming byte
    always_comb
    begin
        in_word  = (st.mode == MODE_WORD) && st.held_valid;
        is_lit   = (in_byte == CH_LT) || (in_byte == CH_GT) ||
                   (!st.text && ((in_byte == CH_QMARK) || (in_byte == CH_EQ) ||
                                 (in_byte == CH_BANG) || (in_byte == CH_SLASH)));
        is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
        is_break = (in_byte == CH_LF) || (in_byte == CH_CR);
        is_quote = (in_byte == CH_DQUOTE) || (in_byte == CH_SQUOTE);
        delim    = st.quote_single ? CH_SQUOTE : CH_DQUOTE;
    end

    // Advance the tokenizer and build up to two results
    always_comb
    begin
        st_next = st;
        res_n   = 2'd0;
        res0    = make_res(in_byte, KIND_LIT, 1'b1, 1'b1);
        res1    = make_res(in_byte, KIND_LIT, 1'b1, 1'b1);
        priority if (st.mode == MODE_STR)
        begin
            res_n = 2'd1;
            if (end_of_input)
            begin
                res0         = make_res(8'h00, KIND_STR, 1'b1, 1'b0);
                st_next.mode = MODE_IDLE;
            end
            else if (in_byte == delim)
            begin
                res0         = make_res(in_byte, KIND_STR, 1'b1, 1'b1);
                st_next.mode = MODE_IDLE;
            end
            else
            begin
                res0 = make_res(in_byte, KIND_STR, 1'b0, 1'b1);
            end
        end
        else if (end_of_input)
        begin
            // close a pending word
            if (in_word)
            begin
                res_n = 2'd1;
                res0  = make_res(st.held_char, KIND_WORD, 1'b1, 1'b1);
            end
            st_next.mode       = MODE_IDLE;
            st_next.held_valid = 1'b0;
        end
        else if (is_lit)
        begin
            if (in_word)
            begin
                res_n = 2'd2;
                res0  = make_res(st.held_char, KIND_WORD, 1'b1, 1'b1);
                res1  = make_res(in_byte, KIND_LIT, 1'b1, 1'b1);
            end
            else
            begin
                res_n = 2'd1;
                res0  = make_res(in_byte, KIND_LIT, 1'b1, 1'b1);
            end
            st_next.text       = (in_byte == CH_GT);
            st_next.mode       = MODE_IDLE;
            st_next.held_valid = 1'b0;
        end
        else if (is_quote && !st.text)
        begin
            if (in_word)
            begin
                res_n = 2'd2;
                res0  = make_res(st.held_char, KIND_WORD, 1'b1, 1'b1);
                res1  = make_res(in_byte, KIND_STR, 1'b0, 1'b1);
            end
            else
            begin
                res_n = 2'd1;
                res0  = make_res(in_byte, KIND_STR, 1'b0, 1'b1);
            end
            st_next.quote_single = (in_byte == CH_SQUOTE);
            st_next.mode         = MODE_STR;
            st_next.held_valid   = 1'b0;
        end
        else if (!in_word)
        begin
            // skip leading blanks, otherwise start a word
            if (is_blank || is_break)
            begin
                st_next.mode       = MODE_IDLE;
                st_next.held_valid = 1'b0;
            end
            else
            begin
                st_next.mode       = MODE_WORD;
                st_next.held_valid = 1'b1;
                st_next.held_char  = in_byte;
            end
        end
        else if (is_blank && !st.text)
        begin
            res_n              = 2'd1;
            res0               = make_res(st.held_char, KIND_WORD, 1'b1, 1'b1);
            st_next.mode       = MODE_IDLE;
            st_next.held_valid = 1'b0;
        end
        else if (is_break && !st.text)
        begin
            // drop line break inside a word
            res_n = 2'd0;
        end
        else
        begin
            res_n             = 2'd1;
            res0              = make_res(st.held_char, KIND_WORD, 1'b0, 1'b1);
            st_next.held_char = in_byte;
        end
    end

endmodule

@@ rtl/mts_checker.sv @@
module mts_checker
    import mts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] token_byte,
    input  logic [1:0] token_kind,
    input  logic       token_last,
    input  logic       has_byte
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_byte) &&
        $stable(token_kind) && $stable(token_last) && $stable(has_byte))
        else $error("stalled result changed");

    // Bare end mark only closes a string
    a_bare_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> token_kind == KIND_STR && token_last &&
        token_byte == 8'h00)
        else $error("bad bare end mark");

    // Literals are single-byte tokens
    a_lit_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_LIT |-> token_last)
        else $error("literal without end mark");

    // Stalled input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte) &&
        $stable(end_of_input))
        else $error("stalled input item changed");

    // Empty queue never stalls the input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with nothing queued");

endmodule

bind markup_token_splitter mts_checker u_mts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_byte   (token_byte),
    .token_kind   (token_kind),
    .token_last   (token_last),
    .has_byte     (has_byte)
);
